[rtl/core/snkb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snkb_pkg: shared types and constants of the snake-beta activation
// Fixed-point constants, divisor reciprocals, load sequencer types.
// ----------------------------------------------------------------------------
package snkb_pkg;

  localparam int CHANNELS = 1024;
  localparam int CH_W     = $clog2(CHANNELS);

  // request codes
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [29:0] LN2_Q30     = 30'd744261118;
  localparam logic [37:0] PI_Q36      = 38'h3243F6A888;
  localparam logic [37:0] HALF_PI_Q36 = PI_Q36 / 2;
  localparam logic [30:0] ONE_Q30     = 31'd1 << 30;

  // round(2^42 / ln2): k estimate = v * EXP_RECIP >> 24
  localparam logic [12:0] EXP_RECIP =
    13'(((64'd1 << 42) + 64'(LN2_Q30) / 2) / 64'(LN2_Q30));
  // floor(2^56 / pi): quotient estimate = (p >> 24) * PI_RECIP >> 32
  localparam logic [18:0] PI_RECIP = 19'((64'd1 << 56) / 64'(PI_Q36));

  // exact floor division by n = 1..13 of a 31-bit value: (t * M) >> SH
  localparam int EXP_SH [13] = '{31, 32, 33, 33, 34, 34, 34, 34, 35, 35, 35, 35, 35};
  localparam logic [32:0] EXP_M [13] = '{
    33'(((64'd1 << 31) + 0) / 1),
    33'(((64'd1 << 32) + 1) / 2),
    33'(((64'd1 << 33) + 2) / 3),
    33'(((64'd1 << 33) + 3) / 4),
    33'(((64'd1 << 34) + 4) / 5),
    33'(((64'd1 << 34) + 5) / 6),
    33'(((64'd1 << 34) + 6) / 7),
    33'(((64'd1 << 34) + 7) / 8),
    33'(((64'd1 << 35) + 8) / 9),
    33'(((64'd1 << 35) + 9) / 10),
    33'(((64'd1 << 35) + 10) / 11),
    33'(((64'd1 << 35) + 11) / 12),
    33'(((64'd1 << 35) + 12) / 13)
  };

  // exact floor division of a 32-bit value by (2n)(2n+1), n = 1..7
  localparam int SIN_SH [7] = '{35, 37, 38, 39, 39, 40, 40};
  localparam logic [32:0] SIN_M [7] = '{
    33'(((64'd1 << 35) + 5) / 6),
    33'(((64'd1 << 37) + 19) / 20),
    33'(((64'd1 << 38) + 41) / 42),
    33'(((64'd1 << 39) + 71) / 72),
    33'(((64'd1 << 39) + 109) / 110),
    33'(((64'd1 << 40) + 155) / 156),
    33'(((64'd1 << 40) + 209) / 210)
  };

  typedef enum logic [2:0] {
    LD_IDLE,
    LD_KEST,
    LD_RED,
    LD_FIX,
    LD_MUL,
    LD_DIV,
    LD_FIN,
    LD_WRITE
  } ld_state_t;

  typedef struct packed {
    logic            we;
    logic [CH_W-1:0] addr;
    logic [31:0]     scale;
    logic [31:0]     gain;
  } ld_wr_t;

endpackage

[rtl/core/snake_beta_activation.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snake_beta_activation: per-channel snake-beta activation
// y = x + gain * sin^2(scale * x), coefficients kept in two channel RAMs.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ----------------------------------------
//  req      in   req_valid/req_ready  req_type, channel, sample, log_alpha,
//                                     log_beta
//  rsp      out  rsp_valid/rsp_ready  result, clipped (one per sample)
//
//  Samples stream at one transaction per clock unless a load runs or the
//  output stalls; path: RAM read, phase multiply, mod-pi reduction, seven
//  two-stage sine terms, square, gain multiply, saturate.
//  A load runs on the iterative exp unit and holds req_ready low through
//  two exponentials, then the RAM write.
//  Stalls: each stage moves when it or any stage downstream has a hole, so a
//  waiting result does not stop intake until the pipe is full.
//  Reset clears valid bits and the load sequencer; the coefficient RAMs
//  are not cleared and a channel must be loaded before it is sampled.
// ----------------------------------------------------------------------------
module snake_beta_activation (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_ready,
  input  logic                      req_type,
  input  logic [snkb_pkg::CH_W-1:0] channel,
  input  logic signed [23:0]        sample,
  input  logic signed [15:0]        log_alpha,
  input  logic signed [15:0]        log_beta,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic signed [23:0]        result,
  output logic                      clipped
);

  localparam int NST = 23;

  typedef struct packed {
    logic [31:0]        gain;
    logic signed [23:0] x;
  } side_t;

  logic                accept;
  logic                ld_busy;
  snkb_pkg::ld_wr_t    ld_wr;
  logic [NST-1:0]      vld;
  logic [NST-1:0]      en;

  logic [31:0]         scale_rd;
  logic [31:0]         gain_rd;

  side_t               sd [1:20];
  logic signed [23:0]  x0;
  logic signed [55:0]  p1;
  logic signed [55:0]  p2;
  logic signed [19:0]  qe2;
  logic signed [39:0]  r3;
  logic [30:0]         a4;
  logic [30:0]         it_term [0:6];
  logic [31:0]         it_a2 [0:6];
  logic signed [32:0]  it_s [0:7];
  logic [31:0]         mt_t [0:6];
  logic [31:0]         mt_a2 [0:6];
  logic signed [32:0]  mt_s [0:6];
  logic [30:0]         sin2;
  logic [62:0]         gp;
  logic signed [23:0]  x21;

  // stage datapath nets
  logic signed [56:0]  pprod;
  logic signed [31:0]  ps;
  logic signed [51:0]  qprod;
  logic signed [58:0]  rprod;
  logic signed [58:0]  rdiff;
  logic signed [39:0]  pi_s;
  logic signed [39:0]  r1;
  logic [37:0]         rf;
  logic [37:0]         rfold;
  logic [61:0]         asq;
  logic [30:0]         sc;
  logic [61:0]         sprod;
  logic [63:0]         addw;
  logic [28:0]         addv;
  logic signed [29:0]  y;

  assign accept    = req_valid && req_ready;
  assign req_ready = !ld_busy && en[0];
  assign rsp_valid = vld[NST-1];

  // a stage may load when it is empty or some stage after it has a hole
  for (genvar k = 0; k < NST; k++) begin : g_en
    assign en[k] = rsp_ready | ~(&vld[NST-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NST; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? (accept && (req_type == snkb_pkg::REQ_SAMPLE))
                             : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  snkb_load u_load (
    .clk       (clk),
    .rst       (rst),
    .start     (accept && (req_type == snkb_pkg::REQ_LOAD)),
    .channel   (channel),
    .log_alpha (log_alpha),
    .log_beta  (log_beta),
    .busy      (ld_busy),
    .wr        (ld_wr)
  );

  // stage 0 register is the RAM read data
  snkb_ram #(.WIDTH(32), .DEPTH(snkb_pkg::CHANNELS)) u_scale_ram (
    .clk   (clk),
    .we    (ld_wr.we),
    .waddr (ld_wr.addr),
    .wdata (ld_wr.scale),
    .re    (en[0]),
    .raddr (channel),
    .rdata (scale_rd)
  );

  snkb_ram #(.WIDTH(32), .DEPTH(snkb_pkg::CHANNELS)) u_gain_ram (
    .clk   (clk),
    .we    (ld_wr.we),
    .waddr (ld_wr.addr),
    .wdata (ld_wr.gain),
    .re    (en[0]),
    .raddr (channel),
    .rdata (gain_rd)
  );

  always_comb begin
    // phase p = scale * x, Q.36
    pprod = $signed({1'b0, scale_rd}) * x0;
    // quotient estimate of p / pi, within one of the floor
    ps    = 32'(p1 >>> 24);
    qprod = ps * $signed({1'b0, snkb_pkg::PI_RECIP});
    rprod = qe2 * $signed({1'b0, snkb_pkg::PI_Q36});
    rdiff = {{3{p2[55]}}, p2} - rprod;
    // one correction step, then fold into [0, pi/2]
    pi_s  = $signed({2'b0, snkb_pkg::PI_Q36});
    if (r3 < 40'sd0) begin
      r1 = r3 + pi_s;
    end else if (r3 >= pi_s) begin
      r1 = r3 - pi_s;
    end else begin
      r1 = r3;
    end
    rf    = r1[37:0];
    rfold = (rf > snkb_pkg::HALF_PI_Q36) ? (snkb_pkg::PI_Q36 - rf) : rf;
    asq   = a4 * a4;
    // clamp sine to [0, 1]
    if (it_s[7] < 33'sd0) begin
      sc = '0;
    end else if (it_s[7] > $signed({2'b0, snkb_pkg::ONE_Q30})) begin
      sc = snkb_pkg::ONE_Q30;
    end else begin
      sc = it_s[7][30:0];
    end
    sprod = sc * sc;
    addw  = (64'(gp) + (64'd1 << 33)) >> 34;
    addv  = addw[28:0];
    y     = $signed({{6{x21[23]}}, x21}) + $signed({1'b0, addv});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      x0 <= sample;
    end
    if (en[1]) begin
      p1    <= pprod[55:0];
      sd[1] <= '{gain: gain_rd, x: x0};
    end
    if (en[2]) begin
      qe2   <= 20'(qprod >>> 32);
      p2    <= p1;
      sd[2] <= sd[1];
    end
    if (en[3]) begin
      r3    <= rdiff[39:0];
      sd[3] <= sd[2];
    end
    if (en[4]) begin
      a4    <= 31'(rfold >> 6);
      sd[4] <= sd[3];
    end
    if (en[5]) begin
      it_a2[0]   <= asq[61:30];
      it_term[0] <= a4;
      it_s[0]    <= $signed({2'b0, a4});
      sd[5]      <= sd[4];
    end
    if (en[20]) begin
      sin2   <= sprod[60:30];
      sd[20] <= sd[19];
    end
    if (en[21]) begin
      gp  <= sd[20].gain * sin2;
      x21 <= sd[20].x;
    end
    if (en[22]) begin
      if (y > 30'sd8388607) begin
        result  <= 24'sh7FFFFF;
        clipped <= 1'b1;
      end else if (y < -30'sd8388608) begin
        result  <= -24'sh800000;
        clipped <= 1'b1;
      end else begin
        result  <= y[23:0];
        clipped <= 1'b0;
      end
    end
  end

  // sine series: term_n = floor(floor(term * a^2) / ((2n)(2n+1))),
  // one multiply stage and one reciprocal-divide stage per term
  for (genvar j = 0; j < 7; j++) begin : g_sin
    logic [62:0] mprod;
    logic [64:0] dprod;
    logic [30:0] q;

    assign mprod = it_term[j] * it_a2[j];
    assign dprod = mt_t[j] * snkb_pkg::SIN_M[j];
    assign q     = 31'(dprod >> snkb_pkg::SIN_SH[j]);

    always_ff @(posedge clk) begin
      if (en[6 + 2 * j]) begin
        mt_t[j]       <= mprod[61:30];
        mt_a2[j]      <= it_a2[j];
        mt_s[j]       <= it_s[j];
        sd[6 + 2 * j] <= sd[5 + 2 * j];
      end
    end

    if (j < 6) begin : g_fwd
      always_ff @(posedge clk) begin
        if (en[7 + 2 * j]) begin
          it_term[j + 1] <= q;
          it_a2[j + 1]   <= mt_a2[j];
          sd[7 + 2 * j]  <= sd[6 + 2 * j];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (en[7 + 2 * j]) begin
          sd[7 + 2 * j] <= sd[6 + 2 * j];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[7 + 2 * j]) begin
        if (j % 2 == 0) begin
          it_s[j + 1] <= mt_s[j] - $signed({2'b0, q});
        end else begin
          it_s[j + 1] <= mt_s[j] + $signed({2'b0, q});
        end
      end
    end
  end

endmodule

[rtl/core/snkb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snkb_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module snkb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/snkb_load.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snkb_load: coefficient load sequencer
// Iterative exp unit: scale = exp(log_alpha), gain = exp(-log_beta), Q12.20.
// ----------------------------------------------------------------------------
module snkb_load (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [snkb_pkg::CH_W-1:0] channel,
  input  logic signed [15:0]        log_alpha,
  input  logic signed [15:0]        log_beta,
  output logic                      busy,
  output snkb_pkg::ld_wr_t          wr
);

  snkb_pkg::ld_state_t state, state_next;

  logic [3:0]                idx;
  logic                      second;
  logic [snkb_pkg::CH_W-1:0] ch_q;
  logic signed [15:0]        alpha_q;
  logic signed [15:0]        beta_q;
  logic signed [5:0]         k_q;
  logic signed [31:0]        rr_q;
  logic [29:0]               r_q;
  logic [30:0]               term;
  logic [30:0]               t_q;
  logic [32:0]               sum;
  logic [31:0]               scale_q;
  logic [31:0]               gain_q;

  logic signed [16:0] v_sel;
  logic signed [30:0] kprod;
  logic signed [36:0] big_w;
  logic signed [36:0] kl;
  logic signed [36:0] red;
  logic signed [31:0] ln2_s;
  logic [60:0]        tprod;
  logic [63:0]        dprod;
  logic [30:0]        q;
  logic signed [6:0]  shv;
  logic [6:0]         rs;
  logic [3:0]         lsh;
  logic [40:0]        wide;
  logic [31:0]        res;

  // exponent argument: alpha on the first pass, -beta on the second
  always_comb begin
    v_sel = second ? -$signed({beta_q[15], beta_q}) : $signed({alpha_q[15], alpha_q});
    kprod = v_sel * $signed({1'b0, snkb_pkg::EXP_RECIP});
    big_w = {{2{v_sel[16]}}, v_sel, 18'd0};
    kl    = k_q * $signed({1'b0, snkb_pkg::LN2_Q30});
    red   = big_w - kl;
    ln2_s = $signed({2'b0, snkb_pkg::LN2_Q30});
    tprod = term * r_q;
    dprod = t_q * snkb_pkg::EXP_M[idx];
    q     = 31'(dprod >> snkb_pkg::EXP_SH[idx]);
  end

  // final scaling by 2^(k-10), rounding half up
  always_comb begin
    shv  = {k_q[5], k_q} - 7'sd10;
    rs   = 7'(-shv);
    lsh  = 4'd0;
    wide = '0;
    if (shv > 7'sd0) begin
      lsh  = (shv > 7'sd8) ? 4'd8 : shv[3:0];
      wide = {8'd0, sum} << lsh;
    end else if (rs == 7'd0) begin
      wide = {8'd0, sum};
    end else if (rs > 7'd40) begin
      wide = '0;
    end else begin
      wide = ({8'd0, sum} + (41'd1 << (rs - 7'd1))) >> rs;
    end
    res = (|wide[40:32]) ? 32'hFFFF_FFFF : wide[31:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      snkb_pkg::LD_IDLE:  if (start) state_next = snkb_pkg::LD_KEST;
      snkb_pkg::LD_KEST:  state_next = snkb_pkg::LD_RED;
      snkb_pkg::LD_RED:   state_next = snkb_pkg::LD_FIX;
      snkb_pkg::LD_FIX:   state_next = snkb_pkg::LD_MUL;
      snkb_pkg::LD_MUL:   state_next = snkb_pkg::LD_DIV;
      snkb_pkg::LD_DIV:   state_next = (idx == 4'd12) ? snkb_pkg::LD_FIN : snkb_pkg::LD_MUL;
      snkb_pkg::LD_FIN:   state_next = second ? snkb_pkg::LD_WRITE : snkb_pkg::LD_KEST;
      snkb_pkg::LD_WRITE: state_next = snkb_pkg::LD_IDLE;
      default:            state_next = snkb_pkg::LD_IDLE;
    endcase
  end

  always_comb begin
    busy     = (state != snkb_pkg::LD_IDLE);
    wr.we    = (state == snkb_pkg::LD_WRITE);
    wr.addr  = ch_q;
    wr.scale = scale_q;
    wr.gain  = gain_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snkb_pkg::LD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      snkb_pkg::LD_IDLE: begin
        ch_q    <= channel;
        alpha_q <= log_alpha;
        beta_q  <= log_beta;
        second  <= 1'b0;
      end
      snkb_pkg::LD_KEST: begin
        k_q <= 6'(kprod >>> 24);
      end
      snkb_pkg::LD_RED: begin
        rr_q <= red[31:0];
      end
      snkb_pkg::LD_FIX: begin
        // estimate is off by at most one step of ln2
        if (rr_q < 32'sd0) begin
          r_q <= 30'(rr_q + ln2_s);
          k_q <= k_q - 6'sd1;
        end else if (rr_q >= ln2_s) begin
          r_q <= 30'(rr_q - ln2_s);
          k_q <= k_q + 6'sd1;
        end else begin
          r_q <= rr_q[29:0];
        end
        idx  <= 4'd0;
        term <= snkb_pkg::ONE_Q30;
        sum  <= {2'b0, snkb_pkg::ONE_Q30};
      end
      snkb_pkg::LD_MUL: begin
        t_q <= tprod[60:30];
      end
      snkb_pkg::LD_DIV: begin
        term <= q;
        sum  <= sum + {2'b0, q};
        idx  <= idx + 4'd1;
      end
      snkb_pkg::LD_FIN: begin
        if (second) begin
          gain_q <= res;
        end else begin
          scale_q <= res;
        end
        second <= 1'b1;
      end
      snkb_pkg::LD_WRITE: begin
        second <= 1'b0;
      end
      default: begin
        second <= 1'b0;
      end
    endcase
  end

endmodule

[sim/snake_beta_activation_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snake_beta_activation_test: self-checking bench for the snake-beta block
// Loads channel coefficients, streams samples with bursty sender and stalling
// receiver, and checks every result against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------

// Holds the predicted coefficient tables and the queue of expected results.
class snake_scoreboard;
  logic [31:0] scale_mem [1024];
  logic [31:0] gain_mem [1024];
  logic [24:0] expected_q [$];   // {clipped, result}
  int errors;

  function new();
    errors = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // exp of a Q4.12 value, unsigned Q12.20
  function logic [31:0] exp_fix(longint v);
    longint ln2, big, k, r, sh;
    longint unsigned sum, term, res;
    ln2 = longint'(snkb_pkg::LN2_Q30);
    big = v * 262144;
    k = big / ln2;
    r = big - k * ln2;
    if (r < 0) begin
      r = r + ln2;
      k = k - 1;
    end
    sum = 64'd1 << 30;
    term = sum;
    for (int n = 1; n <= 13; n++) begin
      term = ((term * longint'(r)) >> 30) / n;
      sum = sum + term;
    end
    sh = k - 10;
    if (sh > 0) begin
      if (sh > 8) sh = 8;
      res = sum << sh;
    end else if (sh == 0) begin
      res = sum;
    end else if (-sh > 62) begin
      res = 0;
    end else begin
      res = (sum + (64'd1 << (-sh - 1))) >> (-sh);
    end
    if (res > 64'hFFFF_FFFF) res = 64'hFFFF_FFFF;
    return res[31:0];
  endfunction

  // sin^2(scale * x) in Q.30, phase folded into [0, pi/2]
  function longint unsigned sin_sq(logic [31:0] scale, longint x);
    longint pi, p, r, s;
    longint unsigned a, a2, term;
    pi = longint'(snkb_pkg::PI_Q36);
    p = longint'({32'd0, scale}) * x;
    r = p % pi;
    if (r < 0) r = r + pi;
    if (r > pi / 2) r = pi - r;
    a = r >> 6;
    a2 = (a * a) >> 30;
    term = a;
    s = a;
    for (int n = 1; n <= 7; n++) begin
      term = ((term * a2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    return (longint'(s) * longint'(s)) >> 30;
  endfunction

  // note one accepted request transaction
  function void note_request(logic rtype, logic [9:0] ch, logic signed [23:0] x_in,
                             logic signed [15:0] la, logic signed [15:0] lb);
    longint y;
    longint unsigned add;
    logic clip;
    if (rtype == snkb_pkg::REQ_LOAD) begin
      scale_mem[ch] = exp_fix(longint'(la));
      gain_mem[ch] = exp_fix(-longint'(lb));
      return;
    end
    add = 0;
    if (gain_mem[ch] != 0)
      add = ({32'd0, gain_mem[ch]} * sin_sq(scale_mem[ch], longint'(x_in))
             + (64'd1 << 33)) >> 34;
    y = longint'(x_in) + longint'(add);
    clip = 1'b0;
    if (y > 8388607) begin
      y = 8388607;
      clip = 1'b1;
    end else if (y < -8388608) begin
      y = -8388608;
      clip = 1'b1;
    end
    expected_q.push_back({clip, y[23:0]});
  endfunction

  // compare one accepted response against the oldest prediction
  function void check_response(logic [23:0] res, logic clip);
    logic [24:0] exp_item;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected response result=%h clipped=%b", $time, res, clip);
      errors++;
      return;
    end
    exp_item = expected_q.pop_front();
    if (exp_item[23:0] !== res) begin
      $display("%0t: result mismatch expected=%h actual=%h", $time, exp_item[23:0], res);
      errors++;
    end
    if (exp_item[24] !== clip) begin
      $display("%0t: clipped mismatch expected=%b actual=%b", $time, exp_item[24], clip);
      errors++;
    end
  endfunction
endclass

module snake_beta_activation_test;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  logic req_type;
  logic [snkb_pkg::CH_W-1:0] channel;
  logic signed [23:0] sample;
  logic signed [15:0] log_alpha;
  logic signed [15:0] log_beta;
  logic rsp_valid;
  logic rsp_ready;
  logic signed [23:0] result;
  logic clipped;

  snake_beta_activation dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready),
    .req_type(req_type), .channel(channel), .sample(sample),
    .log_alpha(log_alpha), .log_beta(log_beta),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
    .result(result), .clipped(clipped)
  );

  snake_scoreboard sb = new();

  // channels that hold coefficients; samples only ever target these
  bit loaded [1024];
  int loaded_list [$];

  // sender burst bookkeeping
  int burst_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run (every item a load)
  initial begin
    #5ms;
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver back-pressure: switches among free-running, random, long-stall
  // and mostly-ready modes on its own schedule, independent of the sender.
  int stall_mode;
  int stall_count;
  initial begin
    rsp_ready = 1'b0;
    stall_mode = 0;
    stall_count = 0;
    forever begin
      @(negedge clk);
      if (stall_count == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_count = $urandom_range(20, 200);
      end
      stall_count--;
      case (stall_mode)
        0: rsp_ready = 1'b1;
        1: rsp_ready = ($urandom_range(0, 1) == 1);
        2: rsp_ready = ($urandom_range(0, 7) == 0);
        default: rsp_ready = ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // response monitor; outputs sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready)
      sb.check_response(result, clipped);
  end

  // Present one transaction starting at a falling edge, hold it until it is
  // accepted. Valid is not dropped between back-to-back transactions; gaps
  // between bursts are inserted here.
  task automatic send_req(logic rtype, logic [9:0] ch, logic signed [23:0] x_in,
                          logic signed [15:0] la, logic signed [15:0] lb);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    req_valid = 1'b1;
    req_type = rtype;
    channel = ch;
    sample = x_in;
    log_alpha = la;
    log_beta = lb;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    sb.note_request(rtype, ch, x_in, la, lb);
    if (rtype == snkb_pkg::REQ_LOAD && !loaded[ch]) begin
      loaded[ch] = 1'b1;
      loaded_list.push_back(ch);
    end
    @(negedge clk);
  endtask

  task automatic load_ch(logic [9:0] ch, logic signed [15:0] la, logic signed [15:0] lb);
    send_req(snkb_pkg::REQ_LOAD, ch, 24'($urandom), la, lb);
  endtask

  task automatic sample_ch(logic [9:0] ch, logic signed [23:0] x_in);
    send_req(snkb_pkg::REQ_SAMPLE, ch, x_in, 16'($urandom), 16'($urandom));
  endtask

  function automatic logic signed [15:0] rand_log();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);                       // full range
      1: return 16'sd0 - 16'($urandom_range(0, 12288)); // non-positive logarithms
      default: return 16'($urandom_range(0, 16384)) - 16'sd8192;
    endcase
  endfunction

  function automatic logic signed [23:0] rand_sample();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(0, 65535)) - 24'sd32768;    // near zero
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF - 24'($urandom_range(0, 4096))
                                     : 24'sh800000 + 24'($urandom_range(0, 4096));
      default: return 24'($urandom_range(0, 1048575)) - 24'sd524288;
    endcase
  endfunction

  int wait_cycles;
  int pick;

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_type = snkb_pkg::REQ_LOAD;
    channel = '0;
    sample = '0;
    log_alpha = '0;
    log_beta = '0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: coefficient extremes on the extreme channels.
    load_ch(10'd0, 16'sh7FFF, 16'sh8000);     // max scale, max gain
    load_ch(10'd1023, 16'sh8000, 16'sh7FFF);  // min scale, min gain
    load_ch(10'd5, 16'sd0, 16'sd0);           // unit scale and gain
    load_ch(10'd682, 16'sh7FFF, 16'sh7FFF);
    // sample extremes on each; sign and saturation edges
    sample_ch(10'd0, 24'sh7FFFFF);
    sample_ch(10'd0, 24'sh800000);
    sample_ch(10'd0, 24'sd0);
    sample_ch(10'd0, 24'sh7F0000);
    sample_ch(10'd1023, 24'sh7FFFFF);
    sample_ch(10'd1023, 24'sh800000);
    sample_ch(10'd5, 24'sh7FFFFF);
    sample_ch(10'd5, -24'sd1);
    sample_ch(10'd5, 24'sd1);
    sample_ch(10'd5, 24'sd102944);            // near pi/2 in Q8.16
    sample_ch(10'd5, 24'sd205887);            // near pi
    sample_ch(10'd682, 24'sh7FFFFF);
    sample_ch(10'd682, 24'sh800000);
    // reload overrides the old coefficients
    load_ch(10'd5, 16'sd4096, -16'sd8192);
    sample_ch(10'd5, 24'sd65536);

    // hold off until the pipe has drained completely
    req_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);

    // Random: mostly samples on loaded channels, occasional loads.
    for (int i = 0; i < 1650; i++) begin
      if ($urandom_range(0, 9) == 0 || loaded_list.size() < 8) begin
        load_ch(10'($urandom_range(0, 1023)), rand_log(), rand_log());
      end else begin
        pick = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        sample_ch(10'(pick), rand_sample());
      end
      // second drain, mid run
      if (i == 800) begin
        req_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
      end
    end

    req_valid = 1'b0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 20000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (60) @(negedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/snkb_pkg.sv
rtl/core/snkb_ram.sv
rtl/core/snkb_load.sv
rtl/core/snake_beta_activation.sv
sim/snake_beta_activation_test.sv
